>>> rtl/vector_reflect_unit_assert.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef VECTOR_REFLECT_UNIT_ASSERT_SVH
`define VECTOR_REFLECT_UNIT_ASSERT_SVH

// same-cycle implication
`define VRU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VRU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/vru_pkg.sv
`default_nettype none

package vru_pkg;

	localparam int IN_W   = 32;             // input component width
	localparam int OUT_W  = 18;             // unit component width
	localparam int FRAC_W = 16;             // Q16.16 fraction bits
	localparam int ONE    = 1 << FRAC_W;    // 1.0 in Q16.16

	// normalizer
	localparam int MAG_W  = 64;             // magnitude word
	localparam int SH_N   = $clog2(MAG_W);  // shift steps
	localparam int NRM_W  = 31;             // normalized magnitude
	localparam int SQ_W   = 2 * NRM_W;      // square of one component
	localparam int LEN_W  = MAG_W / 2;      // root width
	localparam int SQ_N   = MAG_W / 2;      // root digits
	localparam int REM_W  = LEN_W + 3;      // root remainder
	localparam int NUM_W  = NRM_W + FRAC_W + 1;
	localparam int DIV_W  = NUM_W + 1;
	localparam int Q_W    = FRAC_W + 1;     // quotient, up to ONE

	// reflection
	localparam int PROD_W = 2 * OUT_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int T_W    = OUT_W + DOT_W;
	localparam int R_W    = 64;
	localparam int DOT_SH = 2 * FRAC_W;

	typedef struct packed {
		logic valid;
		logic flag;
	} side_t;

endpackage

`default_nettype wire

>>> rtl/vru_ifs.sv
`default_nettype none

interface vru_req_if;
	logic                            valid;
	logic                            ready;
	logic signed [vru_pkg::IN_W-1:0] inc_x;
	logic signed [vru_pkg::IN_W-1:0] inc_y;
	logic signed [vru_pkg::IN_W-1:0] inc_z;
	logic signed [vru_pkg::IN_W-1:0] norm_x;
	logic signed [vru_pkg::IN_W-1:0] norm_y;
	logic signed [vru_pkg::IN_W-1:0] norm_z;

	modport source (output valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z,
		input ready);
	modport sink (input valid, inc_x, inc_y, inc_z, norm_x, norm_y, norm_z,
		output ready);
endinterface

interface vru_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [vru_pkg::OUT_W-1:0] refl_x;
	logic signed [vru_pkg::OUT_W-1:0] refl_y;
	logic signed [vru_pkg::OUT_W-1:0] refl_z;
	logic                             degenerate;

	modport source (output valid, refl_x, refl_y, refl_z, degenerate, input ready);
	modport sink (input valid, refl_x, refl_y, refl_z, degenerate, output ready);
endinterface

`default_nettype wire

>>> rtl/vector_reflect_unit.sv
// Vector reflection unit.
// req (sink): incident vector inc_x/y/z and surface normal norm_x/y/z, signed
//   Q16.16, one item per valid/ready handshake.
// rsp (source): reflected unit vector refl_x/y/z, signed Q2.16 in
//   [-1.0, 1.0], and degenerate, set when the incident or the normal had zero
//   length. A zero incident gives a zero result; a zero normal gives the
//   normalized incident.
// Pipeline: 125 register stages. The incident and normal normalizers
//   run side by side (60 stages each: 32 of them for the root digits, 17
//   for the quotient bits), then four reflection stages, a third
//   60-stage normalizer and the output register.
// Throughput: one item per cycle while the pipeline is not frozen by a
//   stall (see below); every stage is a plain pipeline register.
// Reset clears all valid bits and side fields; data registers are not reset.
// Stall: while a result waits in the output register the pipeline keeps
//   moving as long as its last stage is empty, so req.ready stays high; once
//   an item waits behind the output register the whole pipeline freezes and
//   req.ready drops until rsp.ready is seen.
`default_nettype none

module vector_reflect_unit (
	input  logic       clk,
	input  logic       arst_n,
	vru_req_if.sink    req,
	vru_rsp_if.source  rsp
);
	localparam int OUT_W = vru_pkg::OUT_W;
	localparam logic signed [OUT_W-1:0] UNIT_POS = OUT_W'(vru_pkg::ONE);
	localparam logic signed [OUT_W-1:0] UNIT_NEG = -UNIT_POS;

	logic                          en;
	logic                          out_ld;

	vru_pkg::side_t                side_in;
	vru_pkg::side_t                side_i, side_n, side_r, side_o;
	logic                          zero_i, zero_n, zero_o;
	logic [2:0][OUT_W-1:0]         unit_i, unit_n, unit_o;
	logic [2:0][vru_pkg::R_W-1:0]  refl_r;

	logic                          out_v_q;
	logic signed [OUT_W-1:0]       refl_q [3];
	logic                          degen_q;

	// Output register loads when empty or taken; the pipeline also advances
	// when its last stage holds nothing.
	assign out_ld    = !out_v_q || rsp.ready;
	assign en        = out_ld || !side_o.valid;
	assign req.ready = en;

	assign side_in = '{valid: req.valid, flag: 1'b0};

	vru_unitize #(
		.W (vru_pkg::IN_W)
	) u_inc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_in),
		.vec      ({req.inc_z, req.inc_y, req.inc_x}),
		.side_out (side_i),
		.zero     (zero_i),
		.unit     (unit_i)
	);

	vru_unitize #(
		.W (vru_pkg::IN_W)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_in),
		.vec      ({req.norm_z, req.norm_y, req.norm_x}),
		.side_out (side_n),
		.zero     (zero_n),
		.unit     (unit_n)
	);

	// degenerate rides along as the side flag from here on
	vru_reflect u_refl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  ('{valid: side_i.valid && side_n.valid,
			flag: zero_i || zero_n || side_i.flag || side_n.flag}),
		.iu       (unit_i),
		.nu       (unit_n),
		.side_out (side_r),
		.r        (refl_r)
	);

	vru_unitize #(
		.W (vru_pkg::R_W)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_r),
		.vec      (refl_r),
		.side_out (side_o),
		.zero     (zero_o),
		.unit     (unit_o)
	);

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ld) begin
			out_v_q <= side_o.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && side_o.valid) begin
			for (int k = 0; k < 3; k++) begin
				refl_q[k] <= $signed(unit_o[k]);
			end
			degen_q <= side_o.flag;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.refl_x     = refl_q[0];
	assign rsp.refl_y     = refl_q[1];
	assign rsp.refl_z     = refl_q[2];
	assign rsp.degenerate = degen_q;

	// ---- checks
	`include "vector_reflect_unit_assert.svh"

	`VRU_ASSERT_NXT(a_no_drop, side_o.valid && !en, side_o.valid, "item lost at pipeline end")
	`VRU_ASSERT_IMP(a_stall_cause, !req.ready, out_v_q && side_o.valid, "needless input stall")
	`VRU_ASSERT_IMP(a_zero_flag, side_o.valid && zero_o, side_o.flag, "zero result not flagged")
	`VRU_ASSERT_IMP(a_range, out_v_q, refl_q[0] <= UNIT_POS && refl_q[0] >= UNIT_NEG && refl_q[1] <= UNIT_POS && refl_q[1] >= UNIT_NEG && refl_q[2] <= UNIT_POS && refl_q[2] >= UNIT_NEG, "component out of range")

endmodule

`default_nettype wire

>>> rtl/vru_unitize.sv
`default_nettype none

// Pipelined vector normalizer: magnitude, shift to [2^30, 2^31), sum of
// squares, digit-per-stage root, bit-per-stage divide, clamp, sign.
module vru_unitize #(
	parameter int W = vru_pkg::IN_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  vru_pkg::side_t                    side_in,
	input  logic [2:0][W-1:0]                 vec,
	output vru_pkg::side_t                    side_out,
	output logic                              zero,
	output logic [2:0][vru_pkg::OUT_W-1:0]    unit
);
	localparam int MAG_W = vru_pkg::MAG_W;
	localparam int SH_N  = vru_pkg::SH_N;
	localparam int NRM_W = vru_pkg::NRM_W;
	localparam int SQ_W  = vru_pkg::SQ_W;
	localparam int LEN_W = vru_pkg::LEN_W;
	localparam int SQ_N  = vru_pkg::SQ_N;
	localparam int REM_W = vru_pkg::REM_W;
	localparam int NUM_W = vru_pkg::NUM_W;
	localparam int DIV_W = vru_pkg::DIV_W;
	localparam int Q_W   = vru_pkg::Q_W;
	localparam int OUT_W = vru_pkg::OUT_W;
	localparam int FRAC_W = vru_pkg::FRAC_W;

	typedef struct packed {
		vru_pkg::side_t side;
		logic           zero;
		logic [2:0]     neg;
	} ctl_t;

	// shift stages, index 0 is the magnitude stage
	ctl_t                    c_sh_s  [SH_N+1];
	logic [2:0][MAG_W-1:0]   m_sh_s  [SH_N+1];
	// squares
	ctl_t                    c_sq_s;
	logic [2:0][NRM_W-1:0]   n_sq_s;
	logic [2:0][SQ_W-1:0]    sq_sq_s;
	// root stages, index 0 holds the sum
	ctl_t                    c_rt_s  [SQ_N+1];
	logic [2:0][NRM_W-1:0]   n_rt_s  [SQ_N+1];
	logic [MAG_W-1:0]        s_rt_s  [SQ_N+1];
	logic [REM_W-1:0]        rem_rt_s[SQ_N+1];
	logic [LEN_W-1:0]        root_rt_s[SQ_N+1];
	// divide stages, index 0 holds the numerators
	ctl_t                    c_dv_s  [Q_W+1];
	logic [LEN_W-1:0]        len_dv_s[Q_W+1];
	logic [2:0][DIV_W-1:0]   rem_dv_s[Q_W+1];
	logic [2:0][Q_W-1:0]     q_dv_s  [Q_W+1];
	// result
	ctl_t                    c_o_s;
	logic [2:0][OUT_W-1:0]   u_o_s;

	// ---- magnitudes
	logic [2:0][MAG_W-1:0] ext_c;
	logic [2:0][MAG_W-1:0] mag_c;
	logic [2:0]            neg_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ext_c[k] = MAG_W'($signed(vec[k]));
			neg_c[k] = ext_c[k][MAG_W-1];
			mag_c[k] = neg_c[k] ? (~ext_c[k] + MAG_W'(1)) : ext_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_sh_s[0] <= '0;
		end else if (en) begin
			c_sh_s[0] <= '{side: side_in, zero: (mag_c == '0), neg: neg_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_sh_s[0] <= mag_c;
		end
	end

	// ---- left shift until the top bit of the largest is at the MSB
	for (genvar i = 0; i < SH_N; i++) begin : g_sh
		localparam int AMT = 1 << (SH_N - 1 - i);
		logic [MAG_W-1:0]      or_c;
		logic [2:0][MAG_W-1:0] m_c;

		always_comb begin
			or_c = m_sh_s[i][0] | m_sh_s[i][1] | m_sh_s[i][2];
			for (int k = 0; k < 3; k++) begin
				m_c[k] = (or_c[MAG_W-1 -: AMT] == '0) ? (m_sh_s[i][k] << AMT) : m_sh_s[i][k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_sh_s[i+1] <= '0;
			end else if (en) begin
				c_sh_s[i+1] <= c_sh_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_sh_s[i+1] <= m_c;
			end
		end
	end

	// ---- squares; the top NRM_W bits equal the truncated shift result
	logic [2:0][NRM_W-1:0] n_c;
	logic [2:0][SQ_W-1:0]  sq_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_c[k]  = m_sh_s[SH_N][k][MAG_W-1 -: NRM_W];
			sq_c[k] = SQ_W'(n_c[k]) * SQ_W'(n_c[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_sq_s   <= '0;
			c_rt_s[0] <= '0;
		end else if (en) begin
			c_sq_s   <= c_sh_s[SH_N];
			c_rt_s[0] <= c_sq_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_sq_s       <= n_c;
			sq_sq_s      <= sq_c;
			n_rt_s[0]    <= n_sq_s;
			s_rt_s[0]    <= MAG_W'(sq_sq_s[0]) + MAG_W'(sq_sq_s[1]) + MAG_W'(sq_sq_s[2]);
			rem_rt_s[0]  <= '0;
			root_rt_s[0] <= '0;
		end
	end

	// ---- integer square root, one digit per stage
	for (genvar j = 0; j < SQ_N; j++) begin : g_rt
		logic [REM_W-1:0] rsh_c;
		logic [REM_W-1:0] trial_c;
		logic             ge_c;

		always_comb begin
			rsh_c   = {rem_rt_s[j][REM_W-3:0], s_rt_s[j][MAG_W-1 -: 2]};
			trial_c = REM_W'({root_rt_s[j], 2'b01});
			ge_c    = (rsh_c >= trial_c);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_rt_s[j+1] <= '0;
			end else if (en) begin
				c_rt_s[j+1] <= c_rt_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_rt_s[j+1]    <= n_rt_s[j];
				s_rt_s[j+1]    <= s_rt_s[j] << 2;
				rem_rt_s[j+1]  <= ge_c ? (rsh_c - trial_c) : rsh_c;
				root_rt_s[j+1] <= {root_rt_s[j][LEN_W-2:0], ge_c};
			end
		end
	end

	// ---- numerators: m * ONE + len / 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_dv_s[0] <= '0;
		end else if (en) begin
			c_dv_s[0] <= c_rt_s[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_dv_s[0] <= root_rt_s[SQ_N];
			for (int k = 0; k < 3; k++) begin
				rem_dv_s[0][k] <= DIV_W'({n_rt_s[SQ_N][k], FRAC_W'(0)})
					+ DIV_W'(root_rt_s[SQ_N] >> 1);
			end
			q_dv_s[0] <= '0;
		end
	end

	// ---- restoring divide, one quotient bit per stage
	for (genvar j = 0; j < Q_W; j++) begin : g_dv
		localparam int B = Q_W - 1 - j;
		logic [DIV_W-1:0]      dsh_c;
		logic [2:0]            ge_c;

		always_comb begin
			dsh_c = DIV_W'(len_dv_s[j]) << B;
			for (int k = 0; k < 3; k++) begin
				ge_c[k] = (rem_dv_s[j][k] >= dsh_c);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_dv_s[j+1] <= '0;
			end else if (en) begin
				c_dv_s[j+1] <= c_dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_dv_s[j+1] <= len_dv_s[j];
				for (int k = 0; k < 3; k++) begin
					rem_dv_s[j+1][k] <= ge_c[k] ? (rem_dv_s[j][k] - dsh_c) : rem_dv_s[j][k];
					q_dv_s[j+1][k]   <= {q_dv_s[j][k][Q_W-2:0], ge_c[k]};
				end
			end
		end
	end

	// ---- clamp, sign, zero vector
	logic [2:0][OUT_W-1:0] u_c;
	logic [Q_W-1:0]        qc_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qc_c[k] = (q_dv_s[Q_W][k] > Q_W'(vru_pkg::ONE)) ? Q_W'(vru_pkg::ONE)
				: q_dv_s[Q_W][k];
			if (c_dv_s[Q_W].zero) begin
				u_c[k] = '0;
			end else if (c_dv_s[Q_W].neg[k]) begin
				u_c[k] = -OUT_W'(qc_c[k]);
			end else begin
				u_c[k] = OUT_W'(qc_c[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_o_s <= '0;
		end else if (en) begin
			c_o_s <= c_dv_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_o_s <= u_c;
		end
	end

	assign side_out = c_o_s.side;
	assign zero     = c_o_s.zero;
	assign unit     = u_o_s;

endmodule

`default_nettype wire

>>> rtl/vru_reflect.sv
`default_nettype none

// r = i * 2^32 - 2 n (n . i), four stages.
module vru_reflect (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  vru_pkg::side_t                    side_in,
	input  logic [2:0][vru_pkg::OUT_W-1:0]    iu,
	input  logic [2:0][vru_pkg::OUT_W-1:0]    nu,
	output vru_pkg::side_t                    side_out,
	output logic [2:0][vru_pkg::R_W-1:0]      r
);
	localparam int OUT_W  = vru_pkg::OUT_W;
	localparam int PROD_W = vru_pkg::PROD_W;
	localparam int DOT_W  = vru_pkg::DOT_W;
	localparam int T_W    = vru_pkg::T_W;
	localparam int R_W    = vru_pkg::R_W;

	vru_pkg::side_t             c_s1, c_s2, c_s3, c_s4;
	logic signed [OUT_W-1:0]    iu_s1 [3], iu_s2 [3], iu_s3 [3];
	logic signed [OUT_W-1:0]    nu_s1 [3], nu_s2 [3];
	logic signed [PROD_W-1:0]   p_s1  [3];
	logic signed [DOT_W-1:0]    d_s2;
	logic signed [T_W-1:0]      t_s3  [3];
	logic [2:0][R_W-1:0]        r_s4;

	logic signed [PROD_W-1:0]   p_c   [3];
	logic signed [T_W-1:0]      t_c   [3];
	logic signed [R_W-1:0]      ie_c  [3];
	logic signed [R_W-1:0]      te_c  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_c[k]  = $signed(iu[k]) * $signed(nu[k]);
			t_c[k]  = nu_s2[k] * d_s2;
			ie_c[k] = R_W'(iu_s3[k]);
			te_c[k] = R_W'(t_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			c_s2 <= '0;
			c_s3 <= '0;
			c_s4 <= '0;
		end else if (en) begin
			c_s1 <= side_in;
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			c_s4 <= c_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				iu_s1[k] <= $signed(iu[k]);
				nu_s1[k] <= $signed(nu[k]);
				p_s1[k]  <= p_c[k];
				iu_s2[k] <= iu_s1[k];
				nu_s2[k] <= nu_s1[k];
				iu_s3[k] <= iu_s2[k];
				t_s3[k]  <= t_c[k];
				r_s4[k]  <= (ie_c[k] <<< vru_pkg::DOT_SH) - (te_c[k] <<< 1);
			end
			d_s2 <= DOT_W'(p_s1[0]) + DOT_W'(p_s1[1]) + DOT_W'(p_s1[2]);
		end
	end

	assign side_out = c_s4;
	assign r        = r_s4;

endmodule

`default_nettype wire

>>> dv/vru_tb_ifs.sv
`default_nettype none

package vru_tb_pkg;

	typedef struct packed {
		logic signed [vru_pkg::IN_W-1:0] ix, iy, iz, nx, ny, nz;
	} query_t;

	typedef struct packed {
		logic signed [vru_pkg::OUT_W-1:0] rx, ry, rz;
		logic                             degen;
	} reflection_t;
endpackage

`default_nettype wire

>>> dv/vru_checker.sv
`default_nettype none

module vru_checker (
	input  logic clk,
	input  logic arst_n,
	vru_req_if   req,
	vru_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   degen_seen
);

	vru_tb_pkg::reflection_t expected_q[$];

	function automatic longint unsigned root64(longint unsigned s);
		longint unsigned res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > s) bits >>= 2;
		while (bits != 0) begin
			if (s >= res + bits) begin
				s -= res + bits;
				res = (res >> 1) + bits;
			end else begin
				res >>= 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	// scale to unit length in Q16.16; returns 1 for a zero vector
	function automatic bit to_unit(input longint a[3], output longint u[3]);
		longint unsigned m[3];
		bit neg[3];
		longint unsigned mx, s, len, q;
		mx = 0;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			neg[k] = a[k] < 0;
			m[k] = neg[k] ? -a[k] : a[k];
			if (m[k] > mx) mx = m[k];
		end
		if (mx == 0) begin
			for (int k = 0; k < 3; k++) u[k] = 0;
			return 1;
		end
		while (mx >= (64'd1 << 31)) begin
			for (int k = 0; k < 3; k++) m[k] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			for (int k = 0; k < 3; k++) m[k] <<= 1;
			mx <<= 1;
		end
		for (int k = 0; k < 3; k++) s += m[k] * m[k];
		len = root64(s);
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * vru_pkg::ONE + (len >> 1)) / len;
			if (q > vru_pkg::ONE) q = vru_pkg::ONE;
			u[k] = neg[k] ? -longint'(q) : longint'(q);
		end
		return 0;
	endfunction

	function automatic vru_tb_pkg::reflection_t reflect(vru_tb_pkg::query_t qi);
		longint iv[3], nv[3], iu[3], nu[3], r[3], ru[3];
		longint d;
		bit zi, zn;
		vru_tb_pkg::reflection_t res;
		iv = '{qi.ix, qi.iy, qi.iz};
		nv = '{qi.nx, qi.ny, qi.nz};
		zi = to_unit(iv, iu);
		zn = to_unit(nv, nu);
		d = 0;
		for (int k = 0; k < 3; k++) d += nu[k] * iu[k];
		for (int k = 0; k < 3; k++) r[k] = (iu[k] <<< 32) - 2 * nu[k] * d;
		void'(to_unit(r, ru));
		res.rx = ru[0][vru_pkg::OUT_W-1:0];
		res.ry = ru[1][vru_pkg::OUT_W-1:0];
		res.rz = ru[2][vru_pkg::OUT_W-1:0];
		res.degen = zi | zn;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vru_tb_pkg::reflection_t e, got;
		vru_tb_pkg::query_t qi;
		if (!arst_n) begin
			fail_count <= 0;
			degen_seen <= 0;
			pending    <= 0;
		end else begin
			if (req.valid && req.ready) begin
				qi = '{req.inc_x, req.inc_y, req.inc_z, req.norm_x, req.norm_y, req.norm_z};
				expected_q.push_back(reflect(qi));
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.refl_x, rsp.refl_y, rsp.refl_z, rsp.degenerate};
				if (got.degen) degen_seen <= degen_seen + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e !== got) begin
						$display("%0t: mismatch expected x=%0d y=%0d z=%0d dg=%0b actual x=%0d y=%0d z=%0d dg=%0b",
							$time, e.rx, e.ry, e.rz, e.degen, got.rx, got.ry, got.rz, got.degen);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;

	localparam int LATENCY = 125;
	localparam int N_RANDOM = 1750;
	localparam int HOLD_AT = 600;     // items sent before the long hold-off
	localparam int HOLD_LEN = 400;    // cycles of the long hold-off

	logic clk;
	logic arst_n;
	int   fail_count, pending, degen_seen;
	int   sent;

	vru_req_if req ();
	vru_rsp_if rsp ();

	vector_reflect_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	vru_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending),
		.degen_seen(degen_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// component picker: extremes, small values, zeros and full random
	function automatic logic [31:0] pick_comp();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3: return $urandom_range(0, 7) - 3;
			4: return ($urandom_range(0, 131072) - 65536);
			default: return $urandom;
		endcase
	endfunction

	// present one item and hold it until it is taken
	task automatic send(vru_tb_pkg::query_t qi);
		req.valid  <= 1'b1;
		req.inc_x  <= qi.ix;
		req.inc_y  <= qi.iy;
		req.inc_z  <= qi.iz;
		req.norm_x <= qi.nx;
		req.norm_y <= qi.ny;
		req.norm_z <= qi.nz;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	task automatic pause();
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// receiver: stall pattern of its own, free-running bursts and stalls,
	// plus one long hold-off counted here once enough items went in
	initial begin
		int phase;
		int hold_left;
		bit hold_done;
		phase = 0;
		hold_left = 0;
		hold_done = 0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase = (phase + 1) % 40;
			if (!hold_done && sent >= HOLD_AT) begin
				hold_left = HOLD_LEN;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (phase < 15)
				rsp.ready <= 1'b1;     // stretch without stalls
			else
				rsp.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		vru_tb_pkg::query_t directed[$];
		vru_tb_pkg::query_t qi;
		int burst;
		req.valid  <= 1'b0;
		req.inc_x  <= '0;
		req.inc_y  <= '0;
		req.inc_z  <= '0;
		req.norm_x <= '0;
		req.norm_y <= '0;
		req.norm_z <= '0;
		sent = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero incident, zero normal, both zero, extremes, axis cases
		directed.push_back('{0, 0, 0, 32'h10000, 0, 0});
		directed.push_back('{32'h10000, 32'h20000, 0, 0, 0, 0});
		directed.push_back('{0, 0, 0, 0, 0, 0});
		directed.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		directed.push_back('{32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0});
		directed.push_back('{1, 0, 0, 0, 1, 0});
		directed.push_back('{-1, -1, -1, 0, 0, 1});
		directed.push_back('{32'h10000, 32'hFFFF_0000, 0, 0, 32'h10000, 0});
		directed.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		directed.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0});
		directed.push_back('{0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF});
		directed.push_back('{1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1});
		foreach (directed[k]) send(directed[k]);

		// random part in bursts; the receiver's long hold-off fills the pipeline
		while (sent < directed.size() + N_RANDOM) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				qi = '{pick_comp(), pick_comp(), pick_comp(),
					pick_comp(), pick_comp(), pick_comp()};
				send(qi);
			end
			if ($urandom_range(0, 2) == 0) pause();
		end
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Sent %0d reflection queries (directed and random), %0d degenerate results,",
			sent, degen_seen);
		$display("with bursty input gaps, random output stalls and one long backpressure hold.");
		if (fail_count == 0)
			$display("vector_reflect_unit test passed");
		else
			$display("vector_reflect_unit test failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("vector_reflect_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> vector_reflect_unit.f
+incdir+rtl
rtl/vru_pkg.sv
rtl/vru_ifs.sv
rtl/vru_unitize.sv
rtl/vru_reflect.sv
rtl/vector_reflect_unit.sv
dv/vru_tb_ifs.sv
dv/vru_checker.sv
dv/tb.sv
